FILE: sv/php_pkg.sv
// ----------------------------------------------------------------------------
// php_pkg
// Shared types and constants of the packet header parse and filter block.
// ----------------------------------------------------------------------------
package php_pkg;

   // One packet byte as it travels from the input register to the parser
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } php_item_type;

   // Parse phase codes
   localparam logic [2:0] PH_ETH  = 3'd0;
   localparam logic [2:0] PH_TAG  = 3'd1;
   localparam logic [2:0] PH_IP4  = 3'd2;
   localparam logic [2:0] PH_IP6  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   // Ethertypes and IP protocol numbers
   localparam logic [15:0] ETYPE_CTAG = 16'h8100;
   localparam logic [15:0] ETYPE_STAG = 16'h88A8;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_ICMP4 = 8'd1;
   localparam logic [7:0]  PROTO_ICMP6 = 8'd58;

   // Header lengths in bytes, at offset width
   localparam logic [6:0] ETH_HLEN    = 7'd14;
   localparam logic [6:0] TAG_HLEN    = 7'd4;
   localparam logic [6:0] IP4_MIN_LEN = 7'd20;
   localparam logic [6:0] IP6_LEN     = 7'd40;
   localparam logic [6:0] ICMP_LEN    = 7'd8;

   // Byte offsets inside headers
   localparam logic [6:0] ETH_TYPE_HI  = 7'd12;
   localparam logic [6:0] ETH_TYPE_LO  = 7'd13;
   localparam logic [6:0] TAG_TYPE_HI  = 7'd2;
   localparam logic [6:0] TAG_TYPE_LO  = 7'd3;
   localparam logic [6:0] IP4_VER_IHL  = 7'd0;
   localparam logic [6:0] IP4_PROTO    = 7'd9;
   localparam logic [6:0] IP6_NEXT_HDR = 7'd6;
   localparam logic [7:0] ICMP_SEQ_HI  = 8'd6;
   localparam logic [7:0] ICMP_SEQ_LO  = 8'd7;

   localparam logic [6:0] OFFSET_MAX = 7'd127;
   localparam logic [2:0] TAG_LIMIT  = 3'd7;

   // Verdict codes
   localparam logic VERDICT_PASS = 1'b0;
   localparam logic VERDICT_DROP = 1'b1;

endpackage

FILE: sv/php_parse.sv
// ----------------------------------------------------------------------------
// php_parse
// Per-byte header parser state and the verdict for the byte being stepped.
// ----------------------------------------------------------------------------
module php_parse #(
   parameter int MAX_TAGS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  php_pkg::php_item_type item,
   output logic                  verdict
);
   import php_pkg::*;

   logic [6:0]  byte_offset_ff, byte_offset_in;
   logic [6:0]  header_start_ff, header_start_in;
   logic [2:0]  parse_phase_ff, parse_phase_in;
   logic [15:0] next_type_ff, next_type_in;
   logic [2:0]  tag_count_ff, tag_count_in;
   logic [7:0]  upper_protocol_ff, upper_protocol_in;
   logic [6:0]  required_end_ff, required_end_in;
   logic [15:0] echo_sequence_ff, echo_sequence_in;
   logic        drop_pending_ff, drop_pending_in;
   logic [6:0]  icmp_start_ff, icmp_start_in;
   logic        icmp_known_ff, icmp_known_in;

   logic [6:0] rel;
   logic [6:0] disp_start;
   logic       do_disp;
   logic       do_proto;
   logic [6:0] ip4_end;
   logic [6:0] icmp_end;
   logic       tag_room;
   logic       drop;

   always_comb begin
      byte_offset_in    = byte_offset_ff;
      header_start_in   = header_start_ff;
      parse_phase_in    = parse_phase_ff;
      next_type_in      = next_type_ff;
      tag_count_in      = tag_count_ff;
      upper_protocol_in = upper_protocol_ff;
      required_end_in   = required_end_ff;
      echo_sequence_in  = echo_sequence_ff;
      drop_pending_in   = drop_pending_ff;
      icmp_start_in     = icmp_start_ff;
      icmp_known_in     = icmp_known_ff;

      rel        = byte_offset_ff - header_start_ff;
      disp_start = header_start_ff;
      do_disp    = 1'b0;
      do_proto   = 1'b0;
      ip4_end    = header_start_ff + {1'b0, item.data_byte[3:0], 2'b00};
      icmp_end   = icmp_start_ff + ICMP_LEN;

      // capture the echo sequence, big endian
      if (icmp_known_ff) begin
         if ({1'b0, byte_offset_ff} == {1'b0, icmp_start_ff} + ICMP_SEQ_HI) begin
            echo_sequence_in[15:8] = item.data_byte;
         end else if ({1'b0, byte_offset_ff} == {1'b0, icmp_start_ff} + ICMP_SEQ_LO) begin
            echo_sequence_in[7:0] = item.data_byte;
         end
      end

      if (byte_offset_ff >= header_start_ff) begin
         case (parse_phase_ff)
            PH_ETH: begin
               if (rel == ETH_TYPE_HI) begin
                  next_type_in = {item.data_byte, 8'h00};
               end else if (rel == ETH_TYPE_LO) begin
                  next_type_in = next_type_ff | {8'h00, item.data_byte};
                  do_disp      = 1'b1;
                  disp_start   = header_start_ff + ETH_HLEN;
               end
            end
            PH_TAG: begin
               if (rel == TAG_TYPE_HI) begin
                  next_type_in = {item.data_byte, 8'h00};
               end else if (rel == TAG_TYPE_LO) begin
                  next_type_in = next_type_ff | {8'h00, item.data_byte};
                  tag_count_in = tag_count_ff + 3'd1;
                  do_disp      = 1'b1;
                  disp_start   = header_start_ff + TAG_HLEN;
               end
            end
            PH_IP4: begin
               if (rel == IP4_VER_IHL) begin
                  icmp_start_in = ip4_end;
                  icmp_known_in = 1'b1;
                  if (ip4_end > required_end_ff) begin
                     required_end_in = ip4_end;
                  end
               end else if (rel == IP4_PROTO) begin
                  do_proto = 1'b1;
               end
            end
            PH_IP6: begin
               if (rel == IP6_NEXT_HDR) begin
                  do_proto = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // flag ICMP for the sequence check and extend the needed length
      if (do_proto) begin
         upper_protocol_in = item.data_byte;
         if (item.data_byte inside {PROTO_ICMP4, PROTO_ICMP6}) begin
            drop_pending_in = 1'b1;
            if (icmp_end > required_end_ff) begin
               required_end_in = icmp_end;
            end
         end
      end

      // pick the next header from the ethertype just completed
      tag_room = ({1'b0, tag_count_in} < 4'(MAX_TAGS)) && (tag_count_in < TAG_LIMIT);
      if (do_disp) begin
         header_start_in = disp_start;
         if ((next_type_in inside {ETYPE_CTAG, ETYPE_STAG}) && tag_room) begin
            parse_phase_in  = PH_TAG;
            required_end_in = disp_start + TAG_HLEN;
         end else if (next_type_in == ETYPE_IPV6) begin
            parse_phase_in  = PH_IP6;
            required_end_in = disp_start + IP6_LEN;
            icmp_start_in   = disp_start + IP6_LEN;
            icmp_known_in   = 1'b1;
         end else if (next_type_in == ETYPE_IPV4) begin
            parse_phase_in  = PH_IP4;
            required_end_in = disp_start + IP4_MIN_LEN;
         end else begin
            parse_phase_in = PH_DONE;
         end
      end

      drop = ({1'b0, byte_offset_ff} + 8'd1 < {1'b0, required_end_in}) ||
             (drop_pending_in && !echo_sequence_in[0]);
      verdict = drop ? VERDICT_DROP : VERDICT_PASS;

      if (byte_offset_ff < OFFSET_MAX) begin
         byte_offset_in = byte_offset_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && item.last_byte)) begin
         byte_offset_ff    <= '0;
         header_start_ff   <= '0;
         parse_phase_ff    <= PH_ETH;
         next_type_ff      <= '0;
         tag_count_ff      <= '0;
         upper_protocol_ff <= '0;
         required_end_ff   <= ETH_HLEN;
         echo_sequence_ff  <= '0;
         drop_pending_ff   <= 1'b0;
         icmp_start_ff     <= '0;
         icmp_known_ff     <= 1'b0;
      end else if (step_en) begin
         byte_offset_ff    <= byte_offset_in;
         header_start_ff   <= header_start_in;
         parse_phase_ff    <= parse_phase_in;
         next_type_ff      <= next_type_in;
         tag_count_ff      <= tag_count_in;
         upper_protocol_ff <= upper_protocol_in;
         required_end_ff   <= required_end_in;
         echo_sequence_ff  <= echo_sequence_in;
         drop_pending_ff   <= drop_pending_in;
         icmp_start_ff     <= icmp_start_in;
         icmp_known_ff     <= icmp_known_in;
      end
   end

endmodule

FILE: sv/packet_header_parse_filter_core.sv
// ----------------------------------------------------------------------------
// packet_header_parse_filter_core
// Ethernet / VLAN / IPv4 / IPv6 / ICMP header parser with echo filter.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ stream carries packet bytes in wire order, one item per byte,
//   with req_tlast on the final byte. The parser walks the Ethernet header,
//   up to MAX_TAGS (at most 7) 802.1Q/802.1ad tags, an IPv4 or IPv6
//   header and the ICMP header. For every packet exactly one item leaves
//   on the rsp_ stream, after its last byte: verdict 1 drops (a needed
//   header was cut short, or an ICMP echo sequence is even), 0 passes.
//   Other bytes give no result. Throughput: one byte per cycle while no
//   verdict waits on a stalled receiver. A byte is held in the input
//   register, parsed by the logic between it and the result register,
//   and a last byte's verdict is loaded there, driving rsp_tvalid.
//   Reset (synchronous) empties both registers and returns the parser to
//   the start of a packet. When the receiver stalls, the verdict holds in
//   the result register; bytes keep flowing until the next last byte needs
//   that register, and then req_tready drops until the verdict is taken.
// ----------------------------------------------------------------------------
module packet_header_parse_filter_core #(
   parameter int MAX_TAGS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] verdict, [7:1] zero
);
   import php_pkg::*;

   // Input register
   logic         in_valid_ff;
   php_item_type in_item_ff;

   // Result register
   logic rsp_valid_ff;
   logic verdict_ff;

   logic rsp_free;
   logic advance;
   logic verdict;

   // A result slot is free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   // Step the parser; a last byte also needs the result slot
   assign advance  = in_valid_ff && (!in_item_ff.last_byte || rsp_free);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.data_byte <= req_tdata;
         in_item_ff.last_byte <= req_tlast;
      end
   end

   php_parse #(
      .MAX_TAGS (MAX_TAGS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .verdict (verdict)
   );

   // Load a verdict on each last byte; drop the slot once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_item_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_item_ff.last_byte) begin
         verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, verdict_ff};

endmodule

FILE: sv/php_check.sv
// ----------------------------------------------------------------------------
// php_check
// Port-level checks of the packet header parse and filter block.
// ----------------------------------------------------------------------------
module php_check (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // With the result slot empty, input is never backpressured
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while result slot empty");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its verdict
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind packet_header_parse_filter_core php_check u_php_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
